@@ rtl/core/srr_pkg.sv @@
// shared types and constants for the selective repeat receiver
`default_nettype none

package srr_pkg;

	localparam int SEQ_BITS     = 3;
	localparam int SLOT_BITS    = 2;
	localparam int SLOTS        = 4;
	localparam int PAYLOAD_BITS = 64;
	localparam int WIN_BITS     = 3;
	localparam int CNT_BITS     = 3;

	// widest usable window: smaller of slot count and half the sequence space
	localparam logic [WIN_BITS-1:0] WIN_MAX = 3'd4;
	localparam logic [WIN_BITS-1:0] WIN_MIN = 3'd1;
	localparam logic [WIN_BITS-1:0] WIN_RESET = 3'd4;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic [SEQ_BITS-1:0]     seq_num;
		logic                    checksum_good;
		logic [PAYLOAD_BITS-1:0] payload_word;
	} srr_packet_t;

	typedef struct packed {
		logic                    result_kind;
		logic [SEQ_BITS-1:0]     ack_number;
		logic [PAYLOAD_BITS-1:0] delivered_data;
		logic                    last_of_run;
	} srr_result_t;

	// classified packet handed from front to back
	typedef struct packed {
		logic [SEQ_BITS-1:0]     seq_num;
		logic [SLOT_BITS-1:0]    slot;
		logic [PAYLOAD_BITS-1:0] payload_word;
	} srr_cmd_t;

	// handshake between command queue and back end
	typedef struct packed {
		logic valid;
		logic pop;
	} srr_cmd_hs_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} srr_state_t;

endpackage

`default_nettype wire

@@ rtl/core/srr_front.sv @@
// front end: input stage, corrupt packet filter and slot classification
`default_nettype none

module srr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire srr_pkg::srr_packet_t packet,
	input  wire logic                q_full,
	output logic                     q_push,
	output srr_pkg::srr_cmd_t        q_cmd
);
	import srr_pkg::*;

	logic        valid_s1;
	srr_packet_t pkt_s1;
	logic        drain;
	logic        load;

	// stage leaves when it is dropped or the queue has room
	assign drain = valid_s1 && (!pkt_s1.checksum_good || !q_full);
	assign full  = valid_s1 && !drain;
	assign load  = push && !full;

	assign q_push             = valid_s1 && pkt_s1.checksum_good && !q_full;
	assign q_cmd.seq_num      = pkt_s1.seq_num;
	assign q_cmd.slot         = pkt_s1.seq_num[SLOT_BITS-1:0];
	assign q_cmd.payload_word = pkt_s1.payload_word;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			pkt_s1 <= packet;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/srr_cmd_queue.sv @@
// two-entry queue of classified packets between front and back
`default_nettype none

module srr_cmd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire srr_pkg::srr_cmd_t  wr_cmd,
	output logic                    q_full,
	output srr_pkg::srr_cmd_hs_t    hs_out,
	input  wire logic               pop,
	output srr_pkg::srr_cmd_t       rd_cmd
);
	import srr_pkg::*;

	srr_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign q_full       = (cnt_q == 2'd2);
	assign hs_out.valid = (cnt_q != 2'd0);
	assign hs_out.pop   = do_pop;
	assign rd_cmd       = mem_q[rd_ptr_q];
	assign do_push      = push && !q_full;
	assign do_pop       = pop && (cnt_q != 2'd0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/srr_back.sv @@
// back end: window check, slot buffer, in-order delivery and result queue
`default_nettype none

module srr_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [srr_pkg::WIN_BITS-1:0] window_size,
	input  wire srr_pkg::srr_cmd_hs_t       cmd_hs,
	input  wire srr_pkg::srr_cmd_t          cmd,
	output logic                            cmd_pop,
	output logic                            empty,
	input  wire logic                       pop,
	output srr_pkg::srr_result_t            result
);
	import srr_pkg::*;

	srr_state_t            state_q;
	srr_state_t            state_d;
	logic [SEQ_BITS-1:0]   base_q;
	logic [SLOTS-1:0]      filled_q;
	logic [PAYLOAD_BITS-1:0] slot_q [SLOTS];
	logic [SEQ_BITS-1:0]   seq_q;
	logic                  run_q;
	logic [CNT_BITS-1:0]   n_q;

	srr_result_t           oq_q [2];
	logic                  owp_q;
	logic                  orp_q;
	logic [1:0]            ocnt_q;
	logic                  oq_full;
	logic                  oq_pop;

	logic [WIN_BITS-1:0]   eff_win;
	logic [SEQ_BITS-1:0]   offset;
	logic                  in_win;
	logic                  do_store;
	logic                  start_run;
	logic [SLOT_BITS-1:0]  base_slot;
	logic                  deliver;
	logic                  oq_push;
	srr_result_t           res_d;

	// window register clamped to its legal range
	always_comb begin
		if (window_size < WIN_MIN) begin
			eff_win = WIN_MIN;
		end else if (window_size > WIN_MAX) begin
			eff_win = WIN_MAX;
		end else begin
			eff_win = window_size;
		end
	end

	// classification against the current base
	assign offset    = cmd.seq_num - base_q;
	assign in_win    = offset < eff_win;
	assign base_slot = base_q[SLOT_BITS-1:0];
	assign deliver   = run_q && (n_q < eff_win) && filled_q[base_slot];
	assign oq_full   = (ocnt_q == 2'd2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_hs.valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!oq_full && !deliver) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop   = 1'b0;
		do_store  = 1'b0;
		start_run = 1'b0;
		oq_push   = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_hs.valid) begin
					cmd_pop   = 1'b1;
					do_store  = in_win && !filled_q[cmd.slot];
					start_run = in_win && (cmd.seq_num == base_q);
				end
			end
			ST_RUN: begin
				oq_push = !oq_full;
				if (deliver) begin
					res_d.result_kind    = KIND_DELIVER;
					res_d.delivered_data = slot_q[base_slot];
				end else begin
					res_d.result_kind = KIND_ACK;
					res_d.ack_number  = seq_q;
					res_d.last_of_run = 1'b1;
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// sequencer, base and slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			base_q   <= '0;
			filled_q <= '0;
			run_q    <= 1'b0;
			n_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_hs.pop) begin
				run_q <= start_run;
				n_q   <= '0;
			end
			if (do_store) begin
				filled_q[cmd.slot] <= 1'b1;
			end
			if (oq_push && deliver) begin
				filled_q[base_slot] <= 1'b0;
				base_q              <= base_q + 1'b1;
				n_q                 <= n_q + 1'b1;
			end
		end
	end

	// slot payloads and latched sequence number
	always_ff @(posedge clk) begin
		if (do_store) begin
			slot_q[cmd.slot] <= cmd.payload_word;
		end
		if (cmd_pop) begin
			seq_q <= cmd.seq_num;
		end
	end

	// result queue control
	assign oq_pop = pop && (ocnt_q != 2'd0);
	assign empty  = (ocnt_q == 2'd0);
	assign result = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				owp_q <= !owp_q;
			end
			if (oq_pop) begin
				orp_q <= !orp_q;
			end
			if (oq_push && !oq_pop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (oq_pop && !oq_push) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[owp_q] <= res_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/selective_repeat_receiver.sv @@
// top level of the selective repeat receiver
// Usage:
//   Packets enter through a queue-style port: an item is taken at a clock edge
//   with push high and full low. Corrupt packets are dropped without result.
//   Results leave through a queue-style port: while empty is low the oldest
//   result is on result, and pop takes it. Each good packet gives zero to four
//   in-order deliveries followed by one ack with last_of_run set.
//   The window register is written on the cfg channel (cfg_ready is always
//   high); write it only while no packet is in flight.
//   The first result of a packet passes the input stage, the command queue
//   and the back end's classify step before it reaches the result queue.
//   The back end takes no new packet until it has written that packet's ack;
//   that sequencer sets the sustained rate. A two-entry command queue and a
//   two-entry result queue let input and output stall independently.
//   When the result side stalls, the result queue fills, the back end waits,
//   then the command queue and the input stage fill and full rises.
//   Reset clears the base, all slot flags and both queues; the window
//   returns to four.
`default_nettype none

module selective_repeat_receiver (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire srr_pkg::srr_packet_t        packet,
	output logic                             empty,
	input  wire logic                        pop,
	output srr_pkg::srr_result_t             result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [srr_pkg::WIN_BITS-1:0] cfg_data
);
	import srr_pkg::*;

	logic [WIN_BITS-1:0] window_q;
	logic                q_full;
	logic                q_push;
	srr_cmd_t            q_wr_cmd;
	srr_cmd_t            q_rd_cmd;
	srr_cmd_hs_t         cmd_hs;
	logic                cmd_pop;

	assign cfg_ready = 1'b1;

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	srr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.packet (packet),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_wr_cmd)
	);

	srr_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.q_full (q_full),
		.hs_out (cmd_hs),
		.pop    (cmd_pop),
		.rd_cmd (q_rd_cmd)
	);

	srr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (window_q),
		.cmd_hs      (cmd_hs),
		.cmd         (q_rd_cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire

@@ sim/srr_delivery_checker.sv @@
// checker that predicts and compares the deliveries and acks of the selective repeat receiver
`default_nettype none

module srr_delivery_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic                         full,
	input  wire srr_pkg::srr_packet_t         packet,
	input  wire logic                         empty,
	input  wire logic                         pop,
	input  wire srr_pkg::srr_result_t         result,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [srr_pkg::WIN_BITS-1:0] cfg_data,
	output int                                mismatches,
	output int                                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import srr_pkg::*;

	// local copy of the receiver state
	logic [WIN_BITS-1:0]     window_reg;
	logic [SEQ_BITS-1:0]     rx_base;
	logic [SLOTS-1:0]        slot_held;
	logic [PAYLOAD_BITS-1:0] slot_word [SLOTS];
	srr_result_t             due_results [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t ns] srr check: %s", $time, what);
		mismatches++;
	endtask

	// buffer a good packet, release the in-order run, then queue its ack
	function automatic void accept_packet(input srr_packet_t p);
		logic [WIN_BITS-1:0]  win;
		logic [SEQ_BITS-1:0]  offset;
		logic [SLOT_BITS-1:0] slot;
		srr_result_t          r;
		int                   n;
		if (!p.checksum_good)
			return;
		win = window_reg;
		if (win < WIN_MIN)
			win = WIN_MIN;
		if (win > WIN_MAX)
			win = WIN_MAX;
		offset = p.seq_num - rx_base;
		if (offset < win) begin
			slot = p.seq_num[SLOT_BITS-1:0];
			if (!slot_held[slot]) begin
				slot_held[slot] = 1'b1;
				slot_word[slot] = p.payload_word;
			end
			if (p.seq_num == rx_base) begin
				// delivery run is bounded by the window width
				for (n = 0; n < win; n++) begin
					slot = rx_base[SLOT_BITS-1:0];
					if (!slot_held[slot])
						break;
					r.result_kind = KIND_DELIVER;
					r.ack_number = '0;
					r.delivered_data = slot_word[slot];
					r.last_of_run = 1'b0;
					due_results.push_back(r);
					slot_held[slot] = 1'b0;
					rx_base = rx_base + 1'b1;
				end
			end
		end
		r.result_kind = KIND_ACK;
		r.ack_number = p.seq_num;
		r.delivered_data = '0;
		r.last_of_run = 1'b1;
		due_results.push_back(r);
	endfunction

	// compare one taken result with the oldest expectation
	task automatic check_result(input srr_result_t got);
		srr_result_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("unexpected item kind %0d ack %0d data %h last %0d",
				got.result_kind, got.ack_number, got.delivered_data, got.last_of_run));
			return;
		end
		want = due_results.pop_front();
		if (got.result_kind !== want.result_kind)
			report_mismatch($sformatf("result_kind expected %0d got %0d",
				want.result_kind, got.result_kind));
		if (got.ack_number !== want.ack_number)
			report_mismatch($sformatf("ack_number expected %0d got %0d",
				want.ack_number, got.ack_number));
		if (got.delivered_data !== want.delivered_data)
			report_mismatch($sformatf("delivered_data expected %h got %h",
				want.delivered_data, got.delivered_data));
		if (got.last_of_run !== want.last_of_run)
			report_mismatch($sformatf("last_of_run expected %0d got %0d",
				want.last_of_run, got.last_of_run));
	endtask

	// watch all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg = WIN_RESET;
			rx_base = '0;
			slot_held = '0;
			due_results.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				window_reg = cfg_data;
			// a result visible now predates any packet taken at this edge
			if (pop && !empty)
				check_result(result);
			if (push && !full)
				accept_packet(packet);
		end
		outstanding = due_results.size();
	end

endmodule

`default_nettype wire

@@ sim/selective_repeat_receiver_tb.sv @@
// testbench top for the selective repeat receiver: stimulus, flow control and verdict
`default_nettype none

module selective_repeat_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 22;
	localparam int PHASES        = 9;
	localparam int LONG_HOLD     = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	srr_packet_t         packet = '0;
	logic                empty;
	logic                pop = 1'b0;
	srr_result_t         result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [WIN_BITS-1:0] cfg_data = '0;

	int                  mismatches;
	int                  outstanding;
	int                  cycle_count = 0;
	bit                  hold_request = 1'b0;
	bit                  sender_calm = 1'b0;
	bit                  receiver_calm = 1'b0;
	logic [SEQ_BITS-1:0] send_base = '0;
	logic [WIN_BITS-1:0] phase_win [PHASES] = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd5,
		3'd1, 3'd4, 3'd6, 3'd4};

	selective_repeat_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.packet    (packet),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	srr_delivery_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.packet      (packet),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("selective_repeat_receiver: mismatch");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PAYLOAD_BITS-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic srr_packet_t pkt(input logic [SEQ_BITS-1:0] seq, input logic good,
		input logic [PAYLOAD_BITS-1:0] data);
		srr_packet_t p;
		p.seq_num = seq;
		p.checksum_good = good;
		p.payload_word = data;
		return p;
	endfunction

	// offer one packet until taken, then maybe idle
	task automatic send_packet(input srr_packet_t p);
		int gap;
		push <= 1'b1;
		packet <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
		gap = idle_len(sender_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending, wait for every expected item, then let the pipeline settle
	task automatic wait_idle();
		push <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// up to one window of packets from the sender base, shuffled, with losses resent
	task automatic send_burst(input int w, inout int sent);
		logic [SEQ_BITS-1:0] order [4];
		logic [SEQ_BITS-1:0] tmp;
		logic [SEQ_BITS-1:0] retry [$];
		int                  n;
		int                  i;
		int                  j;
		n = $urandom_range(1, w);
		for (i = 0; i < n; i++)
			order[i] = send_base + SEQ_BITS'(i);
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_packet(pkt(order[i], 1'b0, rand64()));
				retry.push_back(order[i]);
			end else begin
				send_packet(pkt(order[i], 1'b1, rand64()));
				sent++;
			end
			// duplicate of something already sent in this burst
			if ($urandom_range(0, 7) == 0) begin
				send_packet(pkt(order[$urandom_range(0, i)], 1'b1, rand64()));
				sent++;
			end
		end
		while (retry.size() > 0) begin
			send_packet(pkt(retry.pop_front(), 1'b1, rand64()));
			sent++;
		end
		send_base = send_base + SEQ_BITS'(n);
	endtask

	// result side: random gaps after each item, one long hold on request
	initial begin
		int popped;
		int gap_left;
		popped = 0;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				popped++;
				if (popped % 40 == 0)
					receiver_calm = !receiver_calm;
				gap_left = idle_len(receiver_calm);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				gap_left = LONG_HOLD;
			end
			if (gap_left > 0) begin
				pop <= 1'b0;
				gap_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int p;
		int w;
		int sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full window: corrupt drop, duplicates, a four-deep release
		write_window(3'd4);
		send_packet(pkt(3'd0, 1'b0, '1));
		send_packet(pkt(3'd1, 1'b1, '0));
		send_packet(pkt(3'd1, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5));
		send_packet(pkt(3'd3, 1'b1, '1));
		send_packet(pkt(3'd2, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A));
		send_packet(pkt(3'd0, 1'b1, rand64()));
		// old duplicate, then too far ahead
		send_packet(pkt(3'd3, 1'b1, rand64()));
		send_packet(pkt(3'd0, 1'b1, rand64()));
		// leave two entries buffered ahead of the base
		send_packet(pkt(3'd5, 1'b1, rand64()));
		send_packet(pkt(3'd6, 1'b1, rand64()));

		// shrink the window while those entries are held
		wait_idle();
		write_window(3'd1);
		send_packet(pkt(3'd6, 1'b1, rand64()));
		send_packet(pkt(3'd4, 1'b1, rand64()));
		send_packet(pkt(3'd5, 1'b1, rand64()));

		// zero acts as one
		wait_idle();
		write_window(3'd0);
		send_packet(pkt(3'd6, 1'b1, rand64()));
		send_packet(pkt(3'd0, 1'b1, rand64()));
		send_packet(pkt(3'd7, 1'b0, rand64()));
		send_packet(pkt(3'd7, 1'b1, rand64()));

		// oversized setting clamps to four; a run from base zero moves it to four
		wait_idle();
		write_window(3'd7);
		send_packet(pkt(3'd3, 1'b1, rand64()));
		send_packet(pkt(3'd4, 1'b1, rand64()));
		send_packet(pkt(3'd7, 1'b1, rand64()));
		send_packet(pkt(3'd2, 1'b1, rand64()));
		send_packet(pkt(3'd1, 1'b1, rand64()));
		send_packet(pkt(3'd0, 1'b1, rand64()));
		send_base = 3'd4;

		// random phases, one window setting each
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			write_window(phase_win[p]);
			w = phase_win[p];
			if (w < WIN_MIN)
				w = WIN_MIN;
			if (w > WIN_MAX)
				w = WIN_MAX;
			sender_calm = (p % 3 == 2);
			if (p == 2)
				hold_request = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: corrupt anywhere, or good but outside the window
					if ($urandom_range(0, 1) == 1) begin
						send_packet(pkt(SEQ_BITS'($urandom_range(0, 7)), 1'b0, rand64()));
					end else begin
						send_packet(pkt(send_base + SEQ_BITS'($urandom_range(w, 7)), 1'b1,
							rand64()));
						sent++;
					end
				end else begin
					send_burst(w, sent);
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("selective_repeat_receiver: match");
		end else begin
			$display("selective_repeat_receiver: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
